### hw/rtl/pfa_pkg.sv
// Shared types, codes and constants of the bitmap page frame allocator.
package pfa_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 48;
  localparam int PAGES_W   = 17;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Default sizing and page geometry (PAGE_BYTES is a power of two)
  localparam int PFA_MAX_PAGES  = 65536;
  localparam int PFA_WORD_BITS  = 32;
  localparam int PAGE_BYTES     = 4096;
  localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
  // One page of map covers 8 * PAGE_BYTES pages
  localparam int MAP_PAGE_SHIFT = PAGE_SHIFT + 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SET,
    ST_FREE_CHK,
    ST_FREE_RNG,
    ST_FREE_DIV,
    ST_FREE_WR,
    ST_DONE
  } pfa_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] free_address;
  } pfa_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              success;
  } pfa_result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } pfa_status_t;

endpackage

### hw/rtl/pfa_map.sv
// Used-page bitmap storage: one write port, one registered read port.
module pfa_map #(
  parameter int WORD_BITS = pfa_pkg::PFA_WORD_BITS,
  parameter int DEPTH     = 2048,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/pfa_div.sv
// Splits a page index into map word and bit position; WORD_BITS is a power of two.
module pfa_div #(
  parameter int MAX_PAGES = pfa_pkg::PFA_MAX_PAGES,
  parameter int WORD_BITS = pfa_pkg::PFA_WORD_BITS,
  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS,
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int PIDX_W    = $clog2(MAX_PAGES),
  localparam int BIT_W     = $clog2(WORD_BITS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PIDX_W-1:0]  dividend,
  output logic               done,
  output logic [WADDR_W-1:0] quot,
  output logic [BIT_W-1:0]   rem
);

  logic               done_r;
  logic [WADDR_W-1:0] quot_r;
  logic [BIT_W-1:0]   rem_r;

  // Done strobe in the cycle after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  // Word index is the upper page index bits, bit position the lower ones
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= WADDR_W'(dividend >> BIT_W);
      rem_r  <= BIT_W'(dividend);
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### hw/rtl/pfa_ctrl.sv
// Command sequencer: init sweep, first-fit scan and free read-modify-write of the map.
module pfa_ctrl #(
  parameter int MAX_PAGES = pfa_pkg::PFA_MAX_PAGES,
  parameter int WORD_BITS = pfa_pkg::PFA_WORD_BITS,
  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS,
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  pfa_pkg::pfa_cmd_t              cmd_in,
  input  logic [pfa_pkg::ADDR_W-1:0]     region_base,
  input  logic [pfa_pkg::PAGES_W-1:0]    region_pages,
  input  logic                           res_take,
  output pfa_pkg::pfa_status_t           status,
  output pfa_pkg::pfa_result_t           result,
  output logic                           mem_we,
  output logic [WADDR_W-1:0]             mem_waddr,
  output logic [WORD_BITS-1:0]           mem_wdata,
  output logic                           mem_re,
  output logic [WADDR_W-1:0]             mem_raddr,
  input  logic [WORD_BITS-1:0]           mem_rdata
);

  import pfa_pkg::*;

  localparam int PCNT_W = $clog2(MAX_PAGES + WORD_BITS + 1);
  localparam int PIDX_W = $clog2(MAX_PAGES);
  localparam int BIT_W  = $clog2(WORD_BITS);

  // Control state
  pfa_state_t state_r, state_nxt;
  logic       map_ready_r, map_ready_nxt;
  logic       pend_r, pend_nxt;

  // Region and scan state
  logic [ADDR_W-1:0]    live_base_r, live_base_nxt;
  logic [PCNT_W-1:0]    live_pages_r, live_pages_nxt;
  logic [PCNT_W-1:0]    map_pages_r, map_pages_nxt;
  logic [ADDR_W-1:0]    free_addr_r, free_addr_nxt;
  pfa_result_t          res_r, res_nxt;
  logic [WADDR_W-1:0]   wptr_r, wptr_nxt;
  logic [PCNT_W-1:0]    wbase_r, wbase_nxt;
  logic [PCNT_W-1:0]    chk_base_r, chk_base_nxt;
  logic [WORD_BITS-1:0] hit_word_r, hit_word_nxt;
  logic [WADDR_W-1:0]   hit_addr_r, hit_addr_nxt;
  logic [BIT_W-1:0]     hit_bit_r, hit_bit_nxt;
  logic [ADDR_W-1:0]    off_r, off_nxt;
  logic                 ge_r, ge_nxt;

  // Derived values
  logic [PCNT_W-1:0]    clamp_pages;
  logic [PCNT_W-1:0]    map_pages_calc;
  logic [WORD_BITS-1:0] init_word;
  logic [BIT_W-1:0]     zero_bit;
  logic                 word_full;
  logic                 base_lt;
  logic                 in_range;
  logic [PCNT_W-1:0]    alloc_idx;
  logic [ADDR_W-1:0]    alloc_addr;

  // Offset divider
  logic               div_start;
  logic               div_done;
  logic [WADDR_W-1:0] div_quot;
  logic [BIT_W-1:0]   div_rem;

  pfa_div #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PIDX_W'(off_r >> PAGE_SHIFT)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Page count clamp and map footprint at init
  always_comb begin
    if (32'(region_pages) > 32'(MAX_PAGES)) begin
      clamp_pages = PCNT_W'(MAX_PAGES);
    end else begin
      clamp_pages = PCNT_W'(region_pages);
    end
    map_pages_calc = PCNT_W'((32'(clamp_pages) + 32'((1 << MAP_PAGE_SHIFT) - 1))
                             >> MAP_PAGE_SHIFT);
  end

  // Init pattern: map pages and pages past the region are used
  always_comb begin
    logic [PCNT_W-1:0] bit_idx;
    for (int b = 0; b < WORD_BITS; b++) begin
      bit_idx      = wbase_r + PCNT_W'(b);
      init_word[b] = (bit_idx < map_pages_r) || (bit_idx >= live_pages_r);
    end
  end

  // Lowest clear bit of the word just read
  always_comb begin
    zero_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!mem_rdata[b]) begin
        zero_bit = BIT_W'(b);
      end
    end
  end

  assign word_full  = &mem_rdata;
  assign base_lt    = (wbase_r < live_pages_r);
  assign in_range   = ge_r && ((off_r >> PAGE_SHIFT) < ADDR_W'(live_pages_r));
  assign alloc_idx  = chk_base_r + PCNT_W'(hit_bit_r);
  assign alloc_addr = live_base_r + (ADDR_W'(alloc_idx) << PAGE_SHIFT);

  // Next state and memory port control
  always_comb begin
    state_nxt      = state_r;
    map_ready_nxt  = map_ready_r;
    pend_nxt       = pend_r;
    live_base_nxt  = live_base_r;
    live_pages_nxt = live_pages_r;
    map_pages_nxt  = map_pages_r;
    free_addr_nxt  = free_addr_r;
    res_nxt        = res_r;
    wptr_nxt       = wptr_r;
    wbase_nxt      = wbase_r;
    chk_base_nxt   = chk_base_r;
    hit_word_nxt   = hit_word_r;
    hit_addr_nxt   = hit_addr_r;
    hit_bit_nxt    = hit_bit_r;
    off_nxt        = off_r;
    ge_nxt         = ge_r;
    mem_we         = 1'b0;
    mem_waddr      = hit_addr_r;
    mem_wdata      = init_word;
    mem_re         = 1'b0;
    mem_raddr      = wptr_r;
    div_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          res_nxt       = '0;
          free_addr_nxt = cmd_in.free_address;
          wptr_nxt      = '0;
          wbase_nxt     = '0;
          chk_base_nxt  = '0;
          pend_nxt      = 1'b0;
          case (cmd_in.cmd)
            CMD_INIT: begin
              live_base_nxt  = region_base;
              live_pages_nxt = clamp_pages;
              map_pages_nxt  = map_pages_calc;
              state_nxt      = ST_INIT;
            end
            CMD_ALLOC: begin
              state_nxt = map_ready_r ? ST_SCAN : ST_DONE;
            end
            CMD_FREE: begin
              state_nxt = map_ready_r ? ST_FREE_CHK : ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // One map word per cycle over the region
      ST_INIT: begin
        if (base_lt) begin
          mem_we    = 1'b1;
          mem_waddr = wptr_r;
          mem_wdata = init_word;
          wptr_nxt  = wptr_r + 1'b1;
          wbase_nxt = wbase_r + PCNT_W'(WORD_BITS);
        end else begin
          map_ready_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end
      end

      // Streamed reads; each cycle checks the word read the cycle before
      ST_SCAN: begin
        if (pend_r && !word_full) begin
          hit_word_nxt = mem_rdata;
          hit_addr_nxt = wptr_r - 1'b1;
          hit_bit_nxt  = zero_bit;
          state_nxt    = ST_SET;
        end else begin
          if (pend_r) begin
            chk_base_nxt = chk_base_r + PCNT_W'(WORD_BITS);
          end
          if (base_lt) begin
            mem_re    = 1'b1;
            mem_raddr = wptr_r;
            wptr_nxt  = wptr_r + 1'b1;
            wbase_nxt = wbase_r + PCNT_W'(WORD_BITS);
            pend_nxt  = 1'b1;
          end else begin
            // No free page in the region
            pend_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SET: begin
        mem_we               = 1'b1;
        mem_waddr            = hit_addr_r;
        mem_wdata            = hit_word_r | (WORD_BITS'(1) << hit_bit_r);
        res_nxt.page_address = alloc_addr;
        res_nxt.success      = 1'b1;
        state_nxt            = ST_DONE;
      end

      ST_FREE_CHK: begin
        ge_nxt    = (free_addr_r >= live_base_r);
        off_nxt   = free_addr_r - live_base_r;
        state_nxt = ST_FREE_RNG;
      end

      ST_FREE_RNG: begin
        if (in_range) begin
          div_start = 1'b1;
          state_nxt = ST_FREE_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_FREE_DIV: begin
        if (div_done) begin
          mem_re       = 1'b1;
          mem_raddr    = div_quot;
          hit_addr_nxt = div_quot;
          hit_bit_nxt  = div_rem;
          state_nxt    = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = hit_addr_r;
        mem_wdata       = mem_rdata & ~(WORD_BITS'(1) << hit_bit_r);
        res_nxt.success = 1'b1;
        state_nxt       = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_ready_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_ready_r <= map_ready_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    live_base_r  <= live_base_nxt;
    live_pages_r <= live_pages_nxt;
    map_pages_r  <= map_pages_nxt;
    free_addr_r  <= free_addr_nxt;
    res_r        <= res_nxt;
    wptr_r       <= wptr_nxt;
    wbase_r      <= wbase_nxt;
    chk_base_r   <= chk_base_nxt;
    hit_word_r   <= hit_word_nxt;
    hit_addr_r   <= hit_addr_nxt;
    hit_bit_r    <= hit_bit_nxt;
    off_r        <= off_nxt;
    ge_r         <= ge_nxt;
  end

  assign status.idle      = (state_r == ST_IDLE);
  assign status.res_valid = (state_r == ST_DONE);
  assign result           = res_r;

endmodule

### hw/rtl/bitmap_page_frame_allocator.sv
// Top level of the first-fit bitmap page frame allocator.
//
// Usage: region_base (index 0) and region_pages (index 1) are written on the
// cfg_ channel (cfg_ready is always high) and sampled by the init command.
// Each input transaction (in_cmd: init, alloc, free) yields exactly one
// output transaction carrying page_address and success. One command is
// worked on at a time; in_stall stays high until its result has moved into
// the output register, so a new command is taken while that result waits.
// Steps per command, with N = ceil(pages / WORD_BITS) map words:
//   init  : all N words written, one map word per cycle.
//   alloc : a streamed read of one map word per cycle, up to N words,
//           until the first word with a clear bit.
//   free  : a range check, a registered split of the page index into map
//           word and bit, then one read-modify-write of that word.
// The output register frees up in the cycle the receiver drops out_stall.
// Reset clears the control state and the region registers; the map needs
// no clearing pass, since init rewrites every word it will later read, and
// alloc and free before the first init report failure.
module bitmap_page_frame_allocator #(
  parameter int MAX_PAGES = pfa_pkg::PFA_MAX_PAGES,
  parameter int WORD_BITS = pfa_pkg::PFA_WORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pfa_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pfa_pkg::ADDR_W-1:0]       in_free_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pfa_pkg::ADDR_W-1:0]       out_page_address,
  output logic                             out_success,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]       cfg_data
);

  import pfa_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [ADDR_W-1:0]  region_base_r;
  logic [PAGES_W-1:0] region_pages_r;
  logic               out_valid_r, out_valid_nxt;
  pfa_result_t        out_res_r;

  pfa_cmd_t    ctrl_cmd;
  pfa_status_t ctrl_status;
  pfa_result_t ctrl_res;
  logic        ctrl_start;
  logic        res_take;

  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WADDR_W-1:0]   mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Input handshake
  assign in_stall              = !ctrl_status.idle;
  assign ctrl_start            = in_valid && !in_stall;
  assign ctrl_cmd.cmd          = in_cmd;
  assign ctrl_cmd.free_address = in_free_address;

  // Result moves into the output register when it is empty or draining
  assign res_take = ctrl_status.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= '0;
      region_pages_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REGION_BASE:  region_base_r  <= cfg_data;
          CFG_REGION_PAGES: region_pages_r <= cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= ctrl_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_page_address = out_res_r.page_address;
  assign out_success      = out_res_r.success;

  pfa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (ctrl_start),
    .cmd_in       (ctrl_cmd),
    .region_base  (region_base_r),
    .region_pages (region_pages_r),
    .res_take     (res_take),
    .status       (ctrl_status),
    .result       (ctrl_res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  pfa_map #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

`ifndef SYNTHESIS
  // An accepted command always leaves the sequencer busy
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_start |=> !ctrl_status.idle)
    else $error("sequencer idle right after accepting a command");

  // A finished result holds until the output register takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_status.res_valid && !res_take |=> ctrl_status.res_valid && $stable(ctrl_res))
    else $error("pending result dropped or changed");

  // A failed result carries a zero address
  assert property (@(posedge clk) disable iff (!rst_n)
    res_take && !ctrl_res.success |-> ctrl_res.page_address == '0)
    else $error("nonzero address on unsuccessful result");
`endif

endmodule

### bench/pfa_checker.sv
// Checker for the page frame allocator: tracks the used map, predicts each result, compares.
module pfa_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pfa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pfa_pkg::ADDR_W-1:0]    in_free_address,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pfa_pkg::ADDR_W-1:0]    out_page_address,
  input  logic                          out_success,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen,
  output int                            pages_granted,
  output int                            alloc_refusals,
  output int                            frees_in_range
);

  import pfa_pkg::*;

  localparam int MAP_WORDS = PFA_MAX_PAGES / PFA_WORD_BITS;

  // Predicted allocator state
  logic [PFA_WORD_BITS-1:0] used_words [MAP_WORDS];
  logic                     map_valid;
  logic [ADDR_W-1:0]        base_reg, live_base;
  logic [PAGES_W-1:0]       pages_reg, live_pages;

  // Predicted results waiting for their transaction on the output side
  pfa_result_t expected_results [$];

  task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Apply one command to the predicted map and return the result it should give
  task automatic predict_frame(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                               output pfa_result_t res);
    int unsigned npages, map_pages, page, w, b;
    logic found;
    logic [ADDR_W-1:0] offset;
    res = '0;
    found = 1'b0;
    page = 0;
    case (cmd)
      CMD_INIT: begin
        // counts past the map size saturate; the map's own pages stay used
        npages = (32'(pages_reg) > PFA_MAX_PAGES) ? PFA_MAX_PAGES : 32'(pages_reg);
        map_pages = ((npages + 7) / 8 + PAGE_BYTES - 1) / PAGE_BYTES;
        live_base = base_reg;
        live_pages = npages[PAGES_W-1:0];
        for (w = 0; w < MAP_WORDS; w++) used_words[w] = '1;
        for (page = map_pages; page < npages; page++)
          used_words[page / PFA_WORD_BITS][page % PFA_WORD_BITS] = 1'b0;
        map_valid = 1'b1;
      end
      CMD_ALLOC: begin
        if (map_valid) begin
          // first fit: lowest clear bit
          for (w = 0; w < MAP_WORDS && !found; w++) begin
            if (used_words[w] != '1) begin
              for (b = 0; b < PFA_WORD_BITS && !found; b++) begin
                if (!used_words[w][b]) begin
                  page = w * PFA_WORD_BITS + b;
                  found = 1'b1;
                end
              end
            end
          end
          if (found && page < live_pages) begin
            used_words[page / PFA_WORD_BITS][page % PFA_WORD_BITS] = 1'b1;
            res.page_address = live_base + (ADDR_W'(page) << PAGE_SHIFT);
            res.success = 1'b1;
          end
        end
      end
      CMD_FREE: begin
        if (map_valid && addr >= live_base) begin
          offset = addr - live_base;
          if ((offset >> PAGE_SHIFT) < live_pages) begin
            page = 32'(offset >> PAGE_SHIFT);
            used_words[page / PFA_WORD_BITS][page % PFA_WORD_BITS] = 1'b0;
            res.success = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pfa_result_t want;
    if (!rst_n) begin
      map_valid = 1'b0;
      base_reg = '0;
      pages_reg = '0;
      live_base = '0;
      live_pages = '0;
      expected_results.delete();
      outstanding = 0;
    end else begin
      // result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing pending", '0, out_page_address);
        end else begin
          want = expected_results.pop_front();
          if (out_page_address !== want.page_address)
            note_mismatch("page_address", want.page_address, out_page_address);
          if (out_success !== want.success)
            note_mismatch("success", ADDR_W'(want.success), ADDR_W'(out_success));
        end
      end

      // register writes, sampled later by init
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REGION_BASE) base_reg = cfg_data;
        else if (cfg_index == CFG_REGION_PAGES) pages_reg = cfg_data[PAGES_W-1:0];
      end

      // command side
      if (in_valid && !in_stall) begin
        predict_frame(in_cmd, in_free_address, want);
        expected_results.push_back(want);
        if (in_cmd == CMD_ALLOC) begin
          if (want.success) pages_granted++;
          else alloc_refusals++;
        end
        if (in_cmd == CMD_FREE && want.success) frees_in_range++;
      end
      outstanding = expected_results.size();
    end
  end

endmodule

### bench/tb.sv
// Testbench top for the page frame allocator: clock, reset, stimulus and verdict.
module tb;
  import pfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REGIONS     = 15;
  localparam int LONG_HOLD   = 250;
  localparam logic [ADDR_W-1:0] TOP_BASE = 48'hFFFF_FFFF_D000;
  localparam logic [ADDR_W-1:0] LOW_BASE = 48'h0000_0010_0000;
  localparam logic [ADDR_W-1:0] ODD_BASE = 48'h0000_1234_5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [ADDR_W-1:0]    in_free_address = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_stall, out_valid, out_success, cfg_ready;
  logic [ADDR_W-1:0]    out_page_address;

  int fail_count, outstanding, results_seen, pages_granted, alloc_refusals, frees_in_range;

  // Stimulus control
  logic        idling = 1'b1;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          cycle_count = 0;
  int          region_count = 0;
  int          big_regions = 0;
  int          burst_left, hold_left;
  int unsigned n_pages, span, idx, batch, pick, k, region_no;
  logic [ADDR_W-1:0] base, addr;

  always #10 clk = ~clk;

  bitmap_page_frame_allocator uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_free_address,
    .out_valid, .out_stall, .out_page_address, .out_success,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pfa_checker frame_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_free_address,
    .out_valid, .out_stall, .out_page_address, .out_success,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .results_seen,
    .pages_granted, .alloc_refusals, .frees_in_range
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results pending", cycle_count, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side back-pressure: short random bursts, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst_left = 0;
      hold_left = 0;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one command, with an optional gap before it, and wait for acceptance
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_free_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Program both region registers; only called with the block idle
  task automatic set_region(input logic [ADDR_W-1:0] b, input int unsigned p);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REGION_BASE;
    cfg_data <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_REGION_PAGES;
    cfg_data <= ADDR_W'(p);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    region_count++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // nothing initialized yet: alloc fails, free ignored, unused code
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '1);
    issue(CMD_UNUSED, '0);
    drain();

    // empty region
    set_region('0, 0);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '0);
    drain();

    // one page, taken by the map itself; freeing it makes it allocatable
    set_region(ODD_BASE, 1);
    issue(CMD_INIT, '1);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, ODD_BASE + 48'h10);
    issue(CMD_ALLOC, '0);
    drain();

    // oversized count saturates; region near the top wraps the address
    set_region(TOP_BASE, (1 << PAGES_W) - 1);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '1);
    issue(CMD_FREE, TOP_BASE - 1);
    issue(CMD_FREE, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_UNUSED, '1);
    drain();

    // small region: region end, last byte, repeated free
    set_region(LOW_BASE, 40);
    issue(CMD_INIT, '0);
    repeat (3) issue(CMD_ALLOC, '0);
    issue(CMD_FREE, LOW_BASE + 40 * PAGE_BYTES);
    issue(CMD_FREE, LOW_BASE + 39 * PAGE_BYTES + PAGE_BYTES - 1);
    issue(CMD_FREE, LOW_BASE + PAGE_BYTES + 7);
    issue(CMD_FREE, LOW_BASE + PAGE_BYTES + 7);
    issue(CMD_ALLOC, '0);
    drain();

    // random regions, each an init followed by mixed traffic
    for (region_no = 0; region_no < REGIONS; region_no++) begin
      idling = (region_no < REGIONS - 3) && (region_no != 6);
      pick = $urandom_range(0, 9);
      if (pick == 0 && big_regions < 2) begin
        // full-size map is slow to init, keep these short
        n_pages = $urandom_range(0, 1) ? PFA_MAX_PAGES
                                       : $urandom_range(PFA_MAX_PAGES + 1, (1 << PAGES_W) - 1);
        batch = 12;
        big_regions++;
      end else if (pick == 1) begin
        n_pages = $urandom_range(0, 8);
        batch = 40;
      end else begin
        n_pages = $urandom_range(9, 700);
        batch = 80;
      end
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = ADDR_W'({$urandom, $urandom});
        2: base = TOP_BASE - (ADDR_W'($urandom_range(0, 63)) << PAGE_SHIFT);
        default: base = ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(PAGE_BYTES - 1);
      endcase
      set_region(base, n_pages);
      issue(CMD_INIT, ADDR_W'({$urandom, $urandom}));
      // long receiver hold while commands keep coming
      if (region_no == 1) holds_asked++;

      for (k = 0; k < batch; k++) begin
        pick = $urandom_range(0, 99);
        addr = ADDR_W'({$urandom, $urandom});
        if (pick < 45) begin
          issue(CMD_ALLOC, addr);
        end else if (pick < 80) begin
          // mostly low pages, where first fit hands them out
          span = (pick < 62 && n_pages > 40) ? 40 : n_pages;
          idx = (span == 0) ? 0 : $urandom_range(0, span - 1);
          issue(CMD_FREE, base + (ADDR_W'(idx) << PAGE_SHIFT)
                          + ADDR_W'($urandom_range(0, PAGE_BYTES - 1)));
        end else if (pick < 92) begin
          case ($urandom_range(0, 3))
            0: ;
            1: addr = base - 1 - ADDR_W'($urandom_range(0, 3 * PAGE_BYTES));
            2: addr = base + (ADDR_W'(n_pages) << PAGE_SHIFT)
                      + ADDR_W'($urandom_range(0, 3 * PAGE_BYTES));
            default: addr = '1;
          endcase
          issue(CMD_FREE, addr);
        end else if (pick < 96) begin
          issue(CMD_INIT, addr);
        end else begin
          issue(CMD_UNUSED, addr);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("ran %0d regions, %0d results checked", region_count, results_seen);
    $display("allocs granted %0d, refused %0d; frees in range %0d",
             pages_granted, alloc_refusals, frees_in_range);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results pending", fail_count, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_map.sv
hw/rtl/pfa_div.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/bitmap_page_frame_allocator.sv
bench/pfa_checker.sv
bench/tb.sv
